/* hdl/min_padding_chunk_partition_top_defines.svh */
`ifndef MIN_PADDING_CHUNK_PARTITION_TOP_DEFINES_SVH
`define MIN_PADDING_CHUNK_PARTITION_TOP_DEFINES_SVH

// same-cycle implication
`define MPCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mpcp_pkg.sv */
`default_nettype none
package mpcp_pkg;

  localparam int MAX_ELEMENTS_DEF = 256;
  localparam int MAX_CHUNKS_DEF   = 8;
  localparam int LEN_W            = 16;
  localparam int END_W            = 8;
  localparam int CFG_W            = 4;
  localparam int PAD_W            = 40;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RA, S_RB, S_RC, S_MUL, S_COL0, S_NEXT,
    S_J0, S_J1, S_L0, S_L1, S_JW, S_BTI, S_B0, S_B1, S_EMIT, S_ERR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_STORE, OP_INIT, OP_RA, OP_RB, OP_RC, OP_MUL, OP_COL0,
    OP_NEXT, OP_J0, OP_J1, OP_L0, OP_L1, OP_JW, OP_BTI, OP_B0, OP_B1
  } dp_op_t;

  typedef struct packed {
    logic too_few;
    logic single;
    logic one_chunk;
    logic i_done;
    logic prev_valid;
    logic l_done;
    logic j_done;
    logic bt_zero;
    logic bt_follow;
    logic last_result;
  } status_t;

endpackage
`default_nettype wire

/* hdl/mpcp_ram.sv */
`default_nettype none
module mpcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/mpcp_ctrl.sv */
`default_nettype none
module mpcp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              last_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire mpcp_pkg::status_t st,
  output mpcp_pkg::dp_op_t       op
);

  mpcp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpcp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = mpcp_pkg::OP_NONE;
    in_stall   = (state != mpcp_pkg::S_IDLE);
    out_valid  = (state == mpcp_pkg::S_EMIT) || (state == mpcp_pkg::S_ERR);
    case (state)
      mpcp_pkg::S_IDLE: begin
        if (in_valid) begin
          op = mpcp_pkg::OP_STORE;
          if (last_item) state_next = mpcp_pkg::S_CHECK;
        end
      end
      mpcp_pkg::S_CHECK: begin
        op = mpcp_pkg::OP_INIT;
        if (st.too_few)     state_next = mpcp_pkg::S_ERR;
        else if (st.single) state_next = mpcp_pkg::S_BTI;
        else                state_next = mpcp_pkg::S_RA;
      end
      mpcp_pkg::S_RA: begin
        op = mpcp_pkg::OP_RA;
        state_next = mpcp_pkg::S_RB;
      end
      mpcp_pkg::S_RB: begin
        op = mpcp_pkg::OP_RB;
        state_next = mpcp_pkg::S_RC;
      end
      mpcp_pkg::S_RC: begin
        op = mpcp_pkg::OP_RC;
        state_next = mpcp_pkg::S_MUL;
      end
      mpcp_pkg::S_MUL: begin
        op = mpcp_pkg::OP_MUL;
        state_next = mpcp_pkg::S_COL0;
      end
      mpcp_pkg::S_COL0: begin
        op = mpcp_pkg::OP_COL0;
        if (!st.one_chunk) state_next = mpcp_pkg::S_J0;
        else if (st.i_done) state_next = mpcp_pkg::S_BTI;
        else state_next = mpcp_pkg::S_NEXT;
      end
      mpcp_pkg::S_NEXT: begin
        op = mpcp_pkg::OP_NEXT;
        state_next = mpcp_pkg::S_RA;
      end
      mpcp_pkg::S_J0: begin
        op = mpcp_pkg::OP_J0;
        state_next = mpcp_pkg::S_J1;
      end
      mpcp_pkg::S_J1: begin
        op = mpcp_pkg::OP_J1;
        state_next = st.prev_valid ? mpcp_pkg::S_L0 : mpcp_pkg::S_JW;
      end
      mpcp_pkg::S_L0: begin
        op = mpcp_pkg::OP_L0;
        state_next = mpcp_pkg::S_L1;
      end
      mpcp_pkg::S_L1: begin
        op = mpcp_pkg::OP_L1;
        state_next = st.l_done ? mpcp_pkg::S_JW : mpcp_pkg::S_L0;
      end
      mpcp_pkg::S_JW: begin
        op = mpcp_pkg::OP_JW;
        if (!st.j_done) state_next = mpcp_pkg::S_J0;
        else if (st.i_done) state_next = mpcp_pkg::S_BTI;
        else state_next = mpcp_pkg::S_NEXT;
      end
      mpcp_pkg::S_BTI: begin
        op = mpcp_pkg::OP_BTI;
        state_next = mpcp_pkg::S_B0;
      end
      mpcp_pkg::S_B0: begin
        op = mpcp_pkg::OP_B0;
        if (st.bt_zero) state_next = mpcp_pkg::S_EMIT;
        else if (st.bt_follow) state_next = mpcp_pkg::S_B1;
        else state_next = mpcp_pkg::S_B0;
      end
      mpcp_pkg::S_B1: begin
        // follow the chunk start mark back one chunk
        op = mpcp_pkg::OP_B1;
        state_next = mpcp_pkg::S_B0;
      end
      mpcp_pkg::S_EMIT: begin
        if (!out_stall && st.last_result) state_next = mpcp_pkg::S_IDLE;
      end
      mpcp_pkg::S_ERR: begin
        if (!out_stall) state_next = mpcp_pkg::S_IDLE;
      end
      default: begin
        state_next = mpcp_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/mpcp_datapath.sv */
`default_nettype none
module mpcp_datapath #(
  parameter int MAX_ELEMENTS = mpcp_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_CHUNKS   = mpcp_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mpcp_pkg::CFG_W-1:0]   cfg_wr_data,
  input  wire logic [mpcp_pkg::LEN_W-1:0]   length,
  input  wire logic                         last_item,
  input  wire mpcp_pkg::dp_op_t             op,
  input  wire logic                         out_take,
  output mpcp_pkg::status_t                 st,
  output logic      [mpcp_pkg::END_W-1:0]   chunk_end,
  output logic                              last_of_run,
  output logic                              too_few_items
);

  localparam int IW    = $clog2(MAX_ELEMENTS);
  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int JW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int KW    = $clog2(MAX_CHUNKS + 1);
  localparam int AW    = IW + JW;
  localparam int PW    = mpcp_pkg::LEN_W + 2 + IW;
  localparam int PADW  = mpcp_pkg::PAD_W;
  localparam int LW    = mpcp_pkg::LEN_W;

  logic [mpcp_pkg::CFG_W-1:0] num_chunks;
  logic [CW-1:0]              count, count_inc, n;
  logic [KW-1:0]              k, k_clamp;
  logic [IW-1:0]              i, l, stop, curm, pos;
  logic [JW-1:0]              j, r;
  logic [LW-1:0]              ei, eim;
  logic signed [PW-1:0]       prod;
  logic signed [PADW-1:0]     col0, col0_sum, cur, cum, p;
  logic                       err;
  logic [IW-1:0]              ends [MAX_CHUNKS];

  logic            elem_we;
  logic [IW-1:0]   elem_waddr, elem_raddr;
  logic [LW-1:0]   elem_rdata;
  logic            best_we;
  logic [AW-1:0]   best_waddr, best_raddr;
  logic [PADW-1:0] best_wdata, best_rdata;
  logic            mark_we;
  logic [AW-1:0]   mark_raddr;
  logic [IW-1:0]   mark_rdata;

  assign count_inc = (32'(count) < MAX_ELEMENTS) ? count + CW'(1) : count;

  always_comb begin
    if (num_chunks == '0) begin
      k_clamp = KW'(1);
    end else if (32'(num_chunks) > MAX_CHUNKS) begin
      k_clamp = KW'(MAX_CHUNKS);
    end else begin
      k_clamp = KW'(num_chunks);
    end
  end

  assign col0_sum = col0 + PADW'(prod);
  assign p        = $signed(best_rdata) + cum;

  // status
  always_comb begin
    st.too_few     = 32'(n) < 32'(k);
    st.single      = (32'(n) == 1);
    st.one_chunk   = (32'(k) == 1);
    st.i_done      = (32'(i) == 32'(n) - 1);
    st.prev_valid  = (32'(j) <= 32'(i) - 1);
    st.l_done      = (l == stop);
    st.j_done      = (32'(j) == ((32'(i) < 32'(k) - 1) ? 32'(i) : 32'(k) - 1));
    st.bt_zero     = (j == '0);
    st.bt_follow   = (32'(j) <= 32'(pos));
    st.last_result = (32'(r) == 32'(k) - 1);
  end

  // memory ports
  always_comb begin
    elem_we    = (op == mpcp_pkg::OP_STORE) && (32'(count) < MAX_ELEMENTS);
    elem_waddr = count[IW-1:0];
    case (op)
      mpcp_pkg::OP_RB: elem_raddr = i - IW'(1);
      mpcp_pkg::OP_L0: elem_raddr = l;
      default:         elem_raddr = i;
    endcase

    best_we    = 1'b0;
    best_waddr = {i, j};
    best_wdata = cur;
    case (op)
      mpcp_pkg::OP_INIT: begin
        best_we    = 1'b1;
        best_waddr = '0;
        best_wdata = '0;
      end
      mpcp_pkg::OP_COL0: begin
        best_we    = 1'b1;
        best_waddr = {i, JW'(0)};
        best_wdata = col0_sum;
      end
      mpcp_pkg::OP_JW: begin
        best_we = 1'b1;
      end
      default: begin
        best_we = 1'b0;
      end
    endcase
    mark_we = (op == mpcp_pkg::OP_JW);

    case (op)
      mpcp_pkg::OP_L0: best_raddr = {l, j - JW'(1)};
      default:         best_raddr = {i - IW'(1), j - JW'(1)};
    endcase
    case (op)
      mpcp_pkg::OP_B0: mark_raddr = {pos, j};
      default:         mark_raddr = {i - IW'(1), j};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_chunks <= mpcp_pkg::CFG_W'(1);
      count      <= '0;
    end else begin
      if (cfg_wr_en) num_chunks <= cfg_wr_data;
      if (op == mpcp_pkg::OP_STORE) begin
        count <= last_item ? '0 : count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      mpcp_pkg::OP_STORE: begin
        if (last_item) begin
          n <= count_inc;
          k <= k_clamp;
        end
      end
      mpcp_pkg::OP_INIT: begin
        err  <= st.too_few;
        i    <= IW'(1);
        col0 <= '0;
      end
      mpcp_pkg::OP_RB: ei  <= elem_rdata;
      mpcp_pkg::OP_RC: eim <= elem_rdata;
      mpcp_pkg::OP_MUL: begin
        prod <= PW'($signed({1'b0, ei}) - $signed({1'b0, eim})) * PW'($signed({1'b0, i}));
      end
      mpcp_pkg::OP_COL0: begin
        col0 <= col0_sum;
        j    <= JW'(1);
      end
      mpcp_pkg::OP_NEXT: i <= i + IW'(1);
      mpcp_pkg::OP_J1: begin
        cur  <= $signed(best_rdata);
        curm <= i - IW'(1);
        stop <= mark_rdata;
        l    <= i - IW'(1);
        cum  <= '0;
      end
      mpcp_pkg::OP_L1: begin
        if (p < cur) begin
          cur  <= p;
          curm <= l;
        end
        cum <= cum + PADW'($signed({1'b0, ei}) - $signed({1'b0, elem_rdata}));
        l   <= l - IW'(1);
      end
      mpcp_pkg::OP_JW: j <= j + JW'(1);
      mpcp_pkg::OP_BTI: begin
        pos <= IW'(n - CW'(1));
        j   <= JW'(k - KW'(1));
        r   <= '0;
      end
      mpcp_pkg::OP_B0: begin
        ends[j] <= pos;
        if (!st.bt_follow && !st.bt_zero) j <= j - JW'(1);
      end
      mpcp_pkg::OP_B1: begin
        pos <= mark_rdata;
        j   <= j - JW'(1);
      end
      default: begin
      end
    endcase
    if (out_take) r <= r + JW'(1);
  end

  assign chunk_end     = err ? '0 : mpcp_pkg::END_W'(ends[r]);
  assign last_of_run   = err | st.last_result;
  assign too_few_items = err;

  mpcp_ram #(.WIDTH(LW), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (length),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  mpcp_ram #(.WIDTH(PADW), .DEPTH(1 << AW)) u_best (
    .clk   (clk),
    .we    (best_we),
    .waddr (best_waddr),
    .wdata (best_wdata),
    .raddr (best_raddr),
    .rdata (best_rdata)
  );

  mpcp_ram #(.WIDTH(IW), .DEPTH(1 << AW)) u_mark (
    .clk   (clk),
    .we    (mark_we),
    .waddr (best_waddr),
    .wdata (curm),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

endmodule
`default_nettype wire

/* hdl/min_padding_chunk_partition_top.sv */
// Collects a nondecreasing sequence of lengths (one word each, last_item closes it),
// then splits it into num_chunks contiguous chunks with least total padding and
// emits one chunk end index per chunk in ascending order, last_of_run on the final
// one; a sequence shorter than the chunk count gives a single word with
// too_few_items set. Words without last_item are accepted back to back while idle.
// After the closing word input is stalled while the block fills its padding table
// per element and chunk, searching back over each chunk window, then traces the
// chunk starts back before the results appear. num_chunks is sampled on the closing
// word (0 counts as 1, above MAX_CHUNKS as MAX_CHUNKS) and is to be written only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "min_padding_chunk_partition_top_defines.svh"
module min_padding_chunk_partition_top #(
  parameter int MAX_ELEMENTS = mpcp_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_CHUNKS   = mpcp_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [mpcp_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [mpcp_pkg::LEN_W-1:0] length,
  input  wire logic                       last_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [mpcp_pkg::END_W-1:0] chunk_end,
  output logic                            last_of_run,
  output logic                            too_few_items
);

  mpcp_pkg::status_t st;
  mpcp_pkg::dp_op_t  op;
  logic              in_stall_i, out_valid_i;

  assign in_stall  = in_stall_i;
  assign out_valid = out_valid_i;

  mpcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall_i),
    .last_item (last_item),
    .out_valid (out_valid_i),
    .out_stall (out_stall),
    .st        (st),
    .op        (op)
  );

  mpcp_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_CHUNKS   (MAX_CHUNKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .length        (length),
    .last_item     (last_item),
    .op            (op),
    .out_take      (out_valid_i && !out_stall),
    .st            (st),
    .chunk_end     (chunk_end),
    .last_of_run   (last_of_run),
    .too_few_items (too_few_items)
  );

  `MPCP_ASSERT_NOW(a_no_in_while_out, clk, rst, in_valid && !in_stall, !out_valid,
    "input word accepted while a result is pending")
  `MPCP_ASSERT_NOW(a_err_single, clk, rst, out_valid && too_few_items, last_of_run,
    "error result not marked last")
  `MPCP_ASSERT_NEXT(a_last_ends_run, clk, rst, out_valid && !out_stall && last_of_run,
    !out_valid, "result after last of run")

endmodule
`default_nettype wire

/* dv/tb_min_padding_chunk_partition_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_min_padding_chunk_partition_top;

  localparam int NELEM = mpcp_pkg::MAX_ELEMENTS_DEF;
  localparam int NCHK  = mpcp_pkg::MAX_CHUNKS_DEF;
  localparam int LEN_W = mpcp_pkg::LEN_W;
  localparam int END_W = mpcp_pkg::END_W;
  localparam int CFG_W = mpcp_pkg::CFG_W;
  localparam int PAD_W = mpcp_pkg::PAD_W;

  typedef struct {
    logic [END_W-1:0] cend;
    logic             lastr;
    logic             few;
  } chunk_word_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic [LEN_W-1:0] length;
  logic last_item;
  logic out_valid;
  logic out_stall;
  logic [END_W-1:0] chunk_end;
  logic last_of_run;
  logic too_few_items;

  min_padding_chunk_partition_top dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .length(length), .last_item(last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .chunk_end(chunk_end), .last_of_run(last_of_run), .too_few_items(too_few_items)
  );

  // partition model state
  logic [LEN_W-1:0] seq_len [NELEM];
  int               seq_cnt;
  logic [CFG_W-1:0] chunks_reg;
  longint           pad_tbl [NELEM][NCHK];
  int               start_tbl [NELEM][NCHK];
  bit               start_ok [NELEM][NCHK];

  chunk_word_t expected_ends[$];
  int errors;
  int words_sent;
  int seqs_closed;
  int ends_seen;
  bit no_gap;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("FAIL min_padding_chunk_partition_top");
    $finish;
  end

  function automatic longint wrap40(longint v);
    logic signed [PAD_W-1:0] t;
    t = v[PAD_W-1:0];
    return longint'(t);
  endfunction

  task automatic partition_sequence();
    int n;
    int k;
    int top;
    int pos;
    int stop;
    longint diff;
    longint cum;
    longint p;
    int ends[NCHK];
    chunk_word_t w;
    n = seq_cnt;
    seq_cnt = 0;
    k = chunks_reg;
    if (k < 1) k = 1;
    if (k > NCHK) k = NCHK;
    seqs_closed++;
    if (n < k) begin
      w.cend = '0; w.lastr = 1'b1; w.few = 1'b1;
      expected_ends.insert(expected_ends.size(), w);
      return;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < NCHK; j++) begin
        pad_tbl[i][j] = 0; start_tbl[i][j] = 0; start_ok[i][j] = 1'b0;
      end
    for (int i = 1; i < n; i++) begin
      diff = longint'(seq_len[i]) - longint'(seq_len[i-1]);
      top = (i < k - 1) ? i : k - 1;
      pad_tbl[i][0] = wrap40(pad_tbl[i-1][0] + diff * i);
      for (int j = 1; j <= top; j++) begin
        pad_tbl[i][j] = pad_tbl[i-1][j-1];
        start_tbl[i][j] = i - 1;
        start_ok[i][j] = 1'b1;
        if (start_ok[i-1][j]) begin
          // search back only down to the previous row's chunk start
          stop = start_tbl[i-1][j];
          cum = 0;
          for (int l = i - 1; l >= stop; l--) begin
            p = wrap40(pad_tbl[l][j-1] + cum);
            if (p < pad_tbl[i][j]) begin
              pad_tbl[i][j] = p;
              start_tbl[i][j] = l;
            end
            cum = wrap40(cum + longint'(seq_len[i]) - longint'(seq_len[l]));
          end
        end
      end
    end
    pos = n - 1;
    for (int j = k - 1; j >= 0; j--) begin
      ends[j] = pos;
      if (j > 0 && pos >= 0 && pos < NELEM && start_ok[pos][j]) pos = start_tbl[pos][j];
    end
    for (int r = 0; r < k; r++) begin
      w.cend = ends[r][END_W-1:0];
      w.lastr = (r == k - 1);
      w.few = 1'b0;
      expected_ends.insert(expected_ends.size(), w);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic send_word(logic [LEN_W-1:0] len, logic closes);
    int gap;
    bit took;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      length <= LEN_W'($urandom);
      last_item <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    length <= len;
    last_item <= closes;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    words_sent++;
    if (seq_cnt < NELEM) begin
      seq_len[seq_cnt] = len;
      seq_cnt++;
    end
    if (closes) partition_sequence();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_ends.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_chunks(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chunks_reg = v;
  endtask

  // n words, nondecreasing from base with steps up to step_max, or fully random
  task automatic send_sequence(int n, bit sorted, int step_max);
    logic [LEN_W-1:0] v;
    v = LEN_W'($urandom_range(0, 2000));
    for (int i = 0; i < n; i++) begin
      if (!sorted) v = LEN_W'($urandom);
      else if (i > 0) v = (int'(v) + step_max > 65535) ? 16'hffff
                          : LEN_W'(int'(v) + int'($urandom_range(0, step_max)));
      send_word(v, i == n - 1);
    end
  endtask

  task automatic test_too_few();
    set_chunks(4'd3);
    send_word(16'd5, 1'b0);
    send_word(16'd9, 1'b1);
    set_chunks(4'd8);
    send_word(16'd1, 1'b1);
  endtask

  task automatic test_chunk_count_edges();
    // zero chunks acts as one, above eight saturates
    set_chunks(4'd0);
    send_word(16'd7, 1'b0);
    send_word(16'd8, 1'b1);
    set_chunks(4'd15);
    send_sequence(9, 1'b1, 50);
    set_chunks(4'd1);
    send_word(16'd0, 1'b1);
  endtask

  task automatic test_field_extremes();
    set_chunks(4'd2);
    send_word(16'd0, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'hffff, 1'b1);
    // decreasing input drives the sums negative
    set_chunks(4'd3);
    send_word(16'hffff, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h0000, 1'b1);
  endtask

  task automatic test_overflow();
    // more words than the store holds, the tail is dropped
    set_chunks(4'd2);
    no_gap = 1'b1;
    send_sequence(NELEM + 2, 1'b1, 3);
    no_gap = 1'b0;
  endtask

  task automatic test_random(int budget);
    int n;
    int r;
    while (words_sent < budget) begin
      if ($urandom_range(0, 2) == 0) set_chunks(CFG_W'($urandom));
      r = $urandom_range(0, 9);
      n = (r == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
      if (r == 1) no_gap = 1'b1;
      send_sequence(n, r != 2, (r < 5) ? 3 : 3000);
      no_gap = 1'b0;
      if (r == 3) wait_idle();
    end
  endtask

  // result side: random stall per word, check at negedge
  int  stall_left;
  bit  out_take;
  chunk_word_t want;

  always @(negedge clk) begin
    out_take = 1'b0;
    if (!rst && out_valid && !out_stall) begin
      out_take = 1'b1;
      ends_seen++;
      if (expected_ends.size() == 0) begin
        report_mismatch("unexpected word, chunk_end", chunk_end, -1);
      end else begin
        want = expected_ends.pop_front();
        if (chunk_end !== want.cend) report_mismatch("chunk_end", chunk_end, want.cend);
        if (last_of_run !== want.lastr)
          report_mismatch("last_of_run", last_of_run, want.lastr);
        if (too_few_items !== want.few)
          report_mismatch("too_few_items", too_few_items, want.few);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_take) begin
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    length = '0;
    last_item = 1'b0;
    errors = 0;
    words_sent = 0;
    seqs_closed = 0;
    ends_seen = 0;
    seq_cnt = 0;
    chunks_reg = 4'd1;
    no_gap = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_too_few();
    test_chunk_count_edges();
    test_field_extremes();
    test_overflow();
    test_random(words_sent + 40);
    wait_idle();
    $display("covered %0d words in %0d sequences, %0d chunk ends checked",
             words_sent, seqs_closed, ends_seen);
    $display("chunk counts 0..15, too-short and overflowing sequences, unsorted input");
    if (errors == 0) begin
      $display("PASS min_padding_chunk_partition_top");
    end else begin
      $display("FAIL min_padding_chunk_partition_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
